// File: hw/rtl/sorted_chunk_tile_store_defines.svh
// Assertion macros for the sorted chunk tile store.
// Included by the top level; uses its clk and arst_n.
`ifndef SORTED_CHUNK_TILE_STORE_DEFINES_SVH
`define SORTED_CHUNK_TILE_STORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SCT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sct check failed");

// Next-cycle implication, checked out of reset
`define SCT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sct check failed");

`endif

// File: hw/rtl/sct_pkg.sv
// Shared types and codes for the sorted chunk tile store.
// Used by sct_ctrl, sct_dp and the top level; no dependencies.
package sct_pkg;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_WRITE  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_EXISTS  = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	localparam logic CFG_RADIUS  = 1'b0;
	localparam logic CFG_DEFAULT = 1'b1;

	localparam logic [3:0] RADIUS_RESET = 4'd4;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] key_x;
		logic signed [15:0] key_y;
		logic signed [15:0] key_z;
		logic signed [7:0]  local_x;
		logic signed [7:0]  local_y;
		logic signed [7:0]  local_z;
		logic signed [31:0] write_value;
	} request_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] read_value;
		logic [4:0]         chunk_total;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       step;
		logic       insert;
		logic       fill;
		logic       access;
		logic       capture;
		logic       commit;
		logic       finish;
		logic [2:0] code;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic precheck_bad;
		logic is_create;
		logic is_write;
		logic search_done;
		logic found;
		logic table_full;
		logic fill_last;
	} dp_stat_t;

endpackage

// File: hw/rtl/sct_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: hw/rtl/sct_ctrl.sv
// Controller state machine for the sorted chunk tile store.
// Depends on sct_pkg for command and status types and codes.
module sct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  sct_pkg::dp_stat_t stat,
	output sct_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_INSERT = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;
	localparam logic [2:0] S_ACCESS = 3'd5;
	localparam logic [2:0] S_WAIT   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Sequence one request
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.precheck_bad) begin
					cmd.finish = 1'b1;
					cmd.code   = sct_pkg::ST_INVALID;
					state_d    = S_DONE;
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (!stat.search_done) begin
					cmd.step = 1'b1;
				end else if (stat.is_create) begin
					if (stat.found) begin
						cmd.finish = 1'b1;
						cmd.code   = sct_pkg::ST_EXISTS;
						state_d    = S_DONE;
					end else if (stat.table_full) begin
						cmd.finish = 1'b1;
						cmd.code   = sct_pkg::ST_FULL;
						state_d    = S_DONE;
					end else begin
						state_d = S_INSERT;
					end
				end else if (!stat.found) begin
					cmd.finish = 1'b1;
					cmd.code   = sct_pkg::ST_MISSING;
					state_d    = S_DONE;
				end else begin
					state_d = S_ACCESS;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_FILL;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					cmd.commit = 1'b1;
					cmd.finish = 1'b1;
					cmd.code   = sct_pkg::ST_OK;
					state_d    = S_DONE;
				end
			end
			S_ACCESS: begin
				cmd.access = 1'b1;
				if (stat.is_write) begin
					cmd.finish = 1'b1;
					cmd.code   = sct_pkg::ST_OK;
					state_d    = S_DONE;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				cmd.capture = 1'b1;
				cmd.finish  = 1'b1;
				cmd.code    = sct_pkg::ST_OK;
				state_d     = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// File: hw/rtl/sct_dp.sv
// Datapath: key table, binary search, insert shift, tile RAM and result.
// Depends on sct_pkg and sct_ram.
module sct_dp #(
	parameter int MAX_CHUNKS = 16,
	parameter int MAX_RADIUS = 8,
	parameter int KEY_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	input  sct_pkg::request_t request,
	input  sct_pkg::dp_cmd_t  cmd,
	output sct_pkg::dp_stat_t stat,
	output sct_pkg::result_t  result
);

	localparam int CW     = $clog2(MAX_CHUNKS + 1);
	localparam int IW     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int STRIDE = MAX_RADIUS * MAX_RADIUS * MAX_RADIUS;
	localparam int DEPTH  = MAX_CHUNKS * STRIDE;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW     = (STRIDE > 1) ? $clog2(STRIDE) : 1;
	localparam int KW     = 3 * KEY_BITS;

	// Configuration registers
	logic [3:0]  radius_q;
	logic [31:0] default_q;

	// Request registers
	logic [1:0]         op_q;
	logic [KW-1:0]      key_q;
	logic [7:0]         lx_q, ly_q, lz_q;
	logic [31:0]        wval_q;

	// Search and table state
	logic [CW-1:0]  lo_q, hi_q, pos_q, count_q;
	logic           found_q;
	logic [KW-1:0]  keys_q  [MAX_CHUNKS];
	logic [IW-1:0]  slots_q [MAX_CHUNKS];
	logic [FW-1:0]  fill_q;
	logic [2:0]     status_q;
	logic [31:0]    rval_q;

	logic [CW-1:0]  mid;
	logic [CW-1:0]  pos_w;
	logic [KW-1:0]  ent;
	logic signed [KEY_BITS-1:0] ex, ey, ez, kx, ky, kz;
	logic           key_eq, key_less;
	logic [5:0]     r_eff;
	logic           loc_ok;
	logic [31:0]    ext_x, ext_y, ext_z;
	logic [KW-1:0]  key_in;
	logic [AW-1:0]  ram_addr;
	logic           ram_we;
	logic [31:0]    ram_wdata;
	logic [31:0]    ram_rdata;

	// Take the low key bits, sign extended from the field
	assign ext_x  = 32'(request.key_x);
	assign ext_y  = 32'(request.key_y);
	assign ext_z  = 32'(request.key_z);
	assign key_in = {ext_x[KEY_BITS-1:0], ext_y[KEY_BITS-1:0], ext_z[KEY_BITS-1:0]};

	// Compare the middle entry with the request key
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign ent      = keys_q[mid[IW-1:0]];
	assign ex       = ent[KW-1 -: KEY_BITS];
	assign ey       = ent[2*KEY_BITS-1 -: KEY_BITS];
	assign ez       = ent[KEY_BITS-1:0];
	assign kx       = key_q[KW-1 -: KEY_BITS];
	assign ky       = key_q[2*KEY_BITS-1 -: KEY_BITS];
	assign kz       = key_q[KEY_BITS-1:0];
	assign key_eq   = (ex == kx) && (ey == ky) && (ez == kz);
	assign key_less = (ex < kx) || ((ex == kx) && ((ey < ky) || ((ey == ky) && (ez < kz))));
	assign pos_w    = found_q ? pos_q : lo_q;

	// Clamp radius and check locals; negative locals read as large
	assign r_eff  = ({2'b00, radius_q} > 6'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : {2'b00, radius_q};
	assign loc_ok = (lx_q < {2'b00, r_eff}) && (ly_q < {2'b00, r_eff})
		&& (lz_q < {2'b00, r_eff});

	always_comb begin
		stat.precheck_bad = (r_eff == 6'd0) || (op_q == sct_pkg::OP_UNUSED)
			|| ((op_q != sct_pkg::OP_CREATE) && !loc_ok);
		stat.is_create    = (op_q == sct_pkg::OP_CREATE);
		stat.is_write     = (op_q == sct_pkg::OP_WRITE);
		stat.search_done  = found_q || (lo_q >= hi_q);
		stat.found        = found_q;
		stat.table_full   = (count_q >= CW'(MAX_CHUNKS));
		stat.fill_last    = (fill_q == FW'(STRIDE - 1));
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= sct_pkg::RADIUS_RESET;
			default_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == sct_pkg::CFG_RADIUS) begin
				radius_q <= cfg_data[3:0];
			end else begin
				default_q <= cfg_data;
			end
		end
	end

	// Control state: search bounds, count, fill counter, status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= '0;
			hi_q     <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			count_q  <= '0;
			fill_q   <= '0;
			status_q <= sct_pkg::ST_OK;
		end else begin
			if (cmd.load) begin
				lo_q    <= '0;
				hi_q    <= count_q;
				found_q <= 1'b0;
			end
			if (cmd.step) begin
				if (key_eq) begin
					found_q <= 1'b1;
					pos_q   <= mid;
				end else if (key_less) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.insert) begin
				fill_q <= '0;
			end
			if (cmd.fill) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.commit) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.finish) begin
				status_q <= cmd.code;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= request.op;
			key_q  <= key_in;
			lx_q   <= request.local_x;
			ly_q   <= request.local_y;
			lz_q   <= request.local_z;
			wval_q <= request.write_value;
			rval_q <= '0;
		end
		if (cmd.capture) begin
			rval_q <= ram_rdata;
		end
		// Shift entries above the insert point up by one
		if (cmd.insert) begin
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				if (CW'(i) == pos_w) begin
					keys_q[i]  <= key_q;
					slots_q[i] <= count_q[IW-1:0];
				end else if (CW'(i) > pos_w) begin
					keys_q[i]  <= keys_q[(i > 0) ? i - 1 : 0];
					slots_q[i] <= slots_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	// Tile RAM port: fill sweep or single access
	always_comb begin
		if (cmd.fill) begin
			ram_addr  = AW'(count_q) * AW'(STRIDE) + AW'(fill_q);
			ram_we    = 1'b1;
			ram_wdata = default_q;
		end else begin
			ram_addr  = AW'(slots_q[pos_q[IW-1:0]]) * AW'(STRIDE)
				+ AW'(lx_q) * AW'(MAX_RADIUS * MAX_RADIUS)
				+ AW'(ly_q) * AW'(MAX_RADIUS) + AW'(lz_q);
			ram_we    = cmd.access && (op_q == sct_pkg::OP_WRITE);
			ram_wdata = wval_q;
		end
	end

	sct_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_tiles (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign result.status      = status_q;
	assign result.read_value  = rval_q;
	assign result.chunk_total = 5'(count_q);

endmodule

// File: hw/rtl/sorted_chunk_tile_store.sv
// Top level of the sorted chunk tile store: controller plus datapath.
// Depends on sct_pkg, sct_ctrl, sct_dp and the assertion macro header.
//
//  channel   handshake              payload
//  request   start, accepted !busy  request (sct_pkg::request_t)
//  result    done, one-cycle strobe result  (sct_pkg::result_t)
//  config    cfg_we, no wait        cfg_index, cfg_data
//
// One request at a time; a binary search takes at most log2(MAX_CHUNKS) + 1
// steps (5 for 16 chunks). Invalid ends after the check; exists, full and
// missing after the search; write after one RAM access; read after access and
// a read capture; successful create after insert and a MAX_RADIUS^3 word tile
// fill through one RAM port. Reset is asynchronous and needs no clearing pass;
// the receiver cannot stall and each result is shown for one cycle.
`include "sorted_chunk_tile_store_defines.svh"

module sorted_chunk_tile_store #(
	parameter int MAX_CHUNKS = 16,
	parameter int MAX_RADIUS = 8,
	parameter int KEY_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sct_pkg::request_t request,
	output logic              done,
	output sct_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data
);

	sct_pkg::dp_cmd_t  cmd;
	sct_pkg::dp_stat_t stat;

	sct_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.stat  (stat),
		.cmd   (cmd)
	);

	sct_dp #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.MAX_RADIUS(MAX_RADIUS),
		.KEY_BITS  (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (request),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	// An accepted request keeps the block busy
	`SCT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// A result strobe lasts one cycle and frees the block
	`SCT_ASSERT_NXT(a_done_frees, done, !done && !busy)
	// Only a successful create changes the chunk count
	`SCT_ASSERT_IMP(a_count_hold, done && (result.status != sct_pkg::ST_OK),
		$stable(result.chunk_total))

endmodule
